// ===== design/max_k_digit_subsequence_core_defines.svh =====
// ----------------------------------------------------------------------------
// max_k_digit_subsequence_core_defines
// assertion macros shared by the largest k-digit subsequence block
// ----------------------------------------------------------------------------
`ifndef MAX_K_DIGIT_SUBSEQUENCE_CORE_DEFINES_SVH
`define MAX_K_DIGIT_SUBSEQUENCE_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define MKDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MKDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MKDS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define MKDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/mkds_pkg.sv =====
// ----------------------------------------------------------------------------
// mkds_pkg
// types and constants for the largest k-digit subsequence block
// ----------------------------------------------------------------------------
package mkds_pkg;

  localparam int DIGIT_W = 4;
  localparam int BEST_W  = 40;

  // largest legal digit; codes above it are clamped to it
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // input word: one digit of a line
  typedef struct packed {
    logic [DIGIT_W-1:0] digit_value;
    logic               last_digit;
  } digit_t;

  // output word: one result per line
  typedef struct packed {
    logic [BEST_W-1:0] best_value;
    logic              too_short;
  } result_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic               step;
    logic               clear;
    logic [DIGIT_W-1:0] digit;
  } cell_ctl_t;

endpackage

// ===== design/mkds_cell.sv =====
// ----------------------------------------------------------------------------
// mkds_cell
// one prefix-length cell: best value of a fixed digit count so far
// ----------------------------------------------------------------------------
`include "max_k_digit_subsequence_core_defines.svh"

module mkds_cell #(
  parameter int CELL_W = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mkds_pkg::cell_ctl_t   ctl,
  input  logic [CELL_W-1:0]     prev_value,
  input  logic                  prev_filled,
  output logic [CELL_W-1:0]     value,
  output logic                  filled,
  output logic [CELL_W-1:0]     value_next,
  output logic                  filled_next
);

  logic [CELL_W+2:0] prod_sum;
  logic [CELL_W-1:0] cand;
  logic              take;

  // shorter value times ten plus the digit, as shift-add
  assign prod_sum = {prev_value, 3'b000} + {1'b0, prev_value, 1'b0}
                  + (CELL_W+3)'(ctl.digit);
  assign cand     = prod_sum[CELL_W-1:0];

  // only a reachable cell may grow
  assign take        = prev_filled && (cand > value);
  assign value_next  = take ? cand : value;
  assign filled_next = filled | prev_filled;

  // cell state, cleared at end of line
  always_ff @(posedge clk) begin
    if (rst) begin
      value  <= '0;
      filled <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.clear) begin
        value  <= '0;
        filled <= 1'b0;
      end else begin
        value  <= value_next;
        filled <= filled_next;
      end
    end
  end

  // fill flags form a thermometer along the chain
  `MKDS_ASSERT_NOW(a_fill_thermo, clk, rst, filled, prev_filled,
    "cell filled before its shorter neighbor")
  // an unreachable cell holds zero
  `MKDS_ASSERT_NOW(a_empty_zero, clk, rst, !filled && !prev_filled, value == '0,
    "unreachable cell holds a nonzero value")

endmodule

// ===== design/max_k_digit_subsequence_core.sv =====
// ----------------------------------------------------------------------------
// max_k_digit_subsequence_core
// largest in-order KEEP-digit subsequence of a streamed digit line
// ----------------------------------------------------------------------------
// Digits arrive on the digit channel, one word per cycle, with last_digit
// set on the final digit of a line. A row of KEEP cells, one per prefix
// length, updates on every accepted digit; cell j passes its old value to
// cell j+1, which takes the larger of its own value and that value times ten
// plus the digit. Digit codes above nine count as nine.
// On the last digit one word leaves on the result channel: best_value, or
// zero with too_short set when the line held fewer than KEEP digits. All
// cells then clear for the next line.
// Throughput: one digit per cycle while digit_ready is high, lines back
// to back with no gap. The result is valid the cycle after the last digit
// is accepted. The limit on clock speed is one cell's shift-add and compare.
// Reset clears every cell and drops result_valid; no setup pass is needed.
// A stalled result is held in the output register; digits are still taken
// in the cycle it is read, and digit_ready drops only while an unread
// result sits and result_ready is low.
// ----------------------------------------------------------------------------
`include "max_k_digit_subsequence_core_defines.svh"

module max_k_digit_subsequence_core #(
  parameter int KEEP = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 digit_valid,
  output logic                 digit_ready,
  input  mkds_pkg::digit_t     digit,
  output logic                 result_valid,
  input  logic                 result_ready,
  output mkds_pkg::result_t    result
);

  // bits for 10**KEEP - 1, never below the result width
  localparam int VAL_W  = (KEEP * 3322 + 999) / 1000;
  localparam int CELL_W = (VAL_W > mkds_pkg::BEST_W) ? VAL_W : mkds_pkg::BEST_W;

  logic                 accept;
  logic                 line_end;
  mkds_pkg::cell_ctl_t  ctl;
  logic [CELL_W-1:0]    chain_value  [0:KEEP];
  logic                 chain_filled [0:KEEP];
  logic [CELL_W-1:0]    tail_value;
  logic                 tail_filled;
  mkds_pkg::result_t    result_next;

  assign digit_ready = !result_valid || result_ready;
  assign accept      = digit_valid && digit_ready;
  assign line_end    = accept && digit.last_digit;

  // broadcast control, digit clamped to nine
  always_comb begin
    ctl.step  = accept;
    ctl.clear = digit.last_digit;
    ctl.digit = (digit.digit_value > mkds_pkg::DIGIT_MAX) ? mkds_pkg::DIGIT_MAX
                                                          : digit.digit_value;
  end

  // head of the chain: empty prefix, always reachable
  assign chain_value[0]  = '0;
  assign chain_filled[0] = 1'b1;

  // row of cells
  for (genvar j = 1; j <= KEEP; j++) begin : g_cell
    if (j == KEEP) begin : g_tail
      mkds_cell #(.CELL_W(CELL_W)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .prev_value  (chain_value[j-1]),
        .prev_filled (chain_filled[j-1]),
        .value       (chain_value[j]),
        .filled      (chain_filled[j]),
        .value_next  (tail_value),
        .filled_next (tail_filled)
      );
    end else begin : g_body
      mkds_cell #(.CELL_W(CELL_W)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .prev_value  (chain_value[j-1]),
        .prev_filled (chain_filled[j-1]),
        .value       (chain_value[j]),
        .filled      (chain_filled[j]),
        .value_next  (),
        .filled_next ()
      );
    end
  end

  // result word from the tail cell's updated state
  always_comb begin
    result_next.too_short  = !tail_filled;
    result_next.best_value = tail_filled ? tail_value[mkds_pkg::BEST_W-1:0] : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (line_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_end) begin
      result <= result_next;
    end
  end

  // a short line reports zero
  `MKDS_ASSERT_NOW(a_short_zero, clk, rst, result_valid && result.too_short,
    result.best_value == '0, "short line with nonzero value")
  // end of line always produces a word
  `MKDS_ASSERT_NEXT(a_line_result, clk, rst, line_end, result_valid,
    "no result after end of line")
  // end of line empties the chain
  `MKDS_ASSERT_NEXT(a_line_clear, clk, rst, line_end,
    !chain_filled[1] && chain_value[KEEP] == '0, "chain not cleared at end of line")

endmodule
